// ----- rtl/kvpsd_pkg.sv -----
`timescale 1ns / 1ps
package kvpsd_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam logic [15:0] MAX_VALUE_BYTES_RESET = 16'hFFFF;

   typedef enum logic [2:0] {
      KIND_PAIR   = 3'd0,
      KIND_HEADER = 3'd1,
      KIND_BYTE   = 3'd2,
      KIND_ERROR  = 3'd3,
      KIND_DONE   = 3'd4
   } kind_type;

   // results caused by one accepted item
   typedef struct packed {
      kind_type first_kind;
      kind_type second_kind;
      logic     has_second;
   } entry_type;

endpackage

// ----- rtl/kvpsd_front.sv -----
`timescale 1ns / 1ps
module kvpsd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data,
   input  logic                data_valid,
   input  logic                end_of_buffer,
   input  logic                csr_write_enable,
   input  logic [15:0]         csr_write_data,
   output logic                push,
   output kvpsd_pkg::entry_type push_entry
);
   import kvpsd_pkg::*;

   typedef enum logic [1:0] {
      PH_TYPE  = 2'd0,
      PH_INT   = 2'd1,
      PH_LEN   = 2'd2,
      PH_BYTES = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  vleft_ff, vleft_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] rtype_ff, rtype_in;
   logic [15:0] bleft_ff, bleft_in;
   logic        err_ff, err_in;
   logic [15:0] max_ff;

   logic        produced;
   kind_type    produced_kind;
   logic        truncated;

   always_comb begin
      logic [3:0]  ones;
      logic        stop;
      logic        done;
      logic [64:0] sum;
      phase_in      = phase_ff;
      vleft_in      = vleft_ff;
      acc_in        = acc_ff;
      rtype_in      = rtype_ff;
      bleft_in      = bleft_ff;
      err_in        = err_ff;
      produced      = 1'b0;
      produced_kind = KIND_PAIR;
      done          = 1'b0;
      ones          = '0;
      stop          = 1'b0;
      sum           = {1'b0, rtype_ff} + {1'b0, acc_in};
      for (int i = 7; i >= 0; i--) begin
         if (!stop && data[i]) begin
            ones = ones + 4'd1;
         end else begin
            stop = 1'b1;
         end
      end
      if (data_valid && !err_ff) begin
         if (phase_ff == PH_BYTES) begin
            bleft_in      = bleft_ff - 16'd1;
            produced      = 1'b1;
            produced_kind = KIND_BYTE;
            if (bleft_in == '0) begin
               phase_in = PH_TYPE;
            end
         end else if (vleft_ff == '0) begin
            acc_in   = (ones < 4'd7) ? {56'b0, data & (8'h7F >> ones)} : '0;
            vleft_in = ones;
            done     = (ones == '0);
         end else begin
            acc_in   = {acc_ff[55:0], data};
            vleft_in = vleft_ff - 4'd1;
            done     = (vleft_in == '0);
         end
      end
      sum = {1'b0, rtype_ff} + {1'b0, acc_in};
      if (done) begin
         case (phase_ff)
            PH_TYPE: begin
               if (sum[64]) begin
                  err_in        = 1'b1;
                  produced      = 1'b1;
                  produced_kind = KIND_ERROR;
               end else begin
                  rtype_in = sum[63:0];
                  phase_in = sum[0] ? PH_LEN : PH_INT;
               end
            end
            PH_INT: begin
               phase_in      = PH_TYPE;
               produced      = 1'b1;
               produced_kind = KIND_PAIR;
            end
            PH_LEN: begin
               produced = 1'b1;
               if ((|acc_in[63:16]) || (acc_in[15:0] > max_ff)) begin
                  err_in        = 1'b1;
                  produced_kind = KIND_ERROR;
               end else begin
                  bleft_in      = acc_in[15:0];
                  phase_in      = (acc_in[15:0] == '0) ? PH_TYPE : PH_BYTES;
                  produced_kind = KIND_HEADER;
               end
            end
            default: begin
            end
         endcase
      end
      truncated = !err_in && (phase_in != PH_TYPE || vleft_in != '0);
   end

   always_comb begin
      push_entry = '{first_kind: produced_kind, second_kind: KIND_DONE, has_second: 1'b0};
      push       = 1'b0;
      if (accept) begin
         if (end_of_buffer) begin
            push = 1'b1;
            if (truncated) begin
               push_entry = '{first_kind: KIND_ERROR, second_kind: KIND_DONE,
                              has_second: 1'b1};
            end else if (produced) begin
               push_entry.has_second = 1'b1;
            end else begin
               push_entry.first_kind = KIND_DONE;
            end
         end else begin
            push = produced;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         vleft_ff <= '0;
         acc_ff   <= '0;
         rtype_ff <= '0;
         bleft_ff <= '0;
         err_ff   <= 1'b0;
         max_ff   <= MAX_VALUE_BYTES_RESET;
      end else begin
         if (csr_write_enable) begin
            max_ff <= csr_write_data;
         end
         if (accept) begin
            if (end_of_buffer) begin
               phase_ff <= PH_TYPE;
               vleft_ff <= '0;
               acc_ff   <= '0;
               rtype_ff <= '0;
               bleft_ff <= '0;
               err_ff   <= 1'b0;
            end else begin
               phase_ff <= phase_in;
               vleft_ff <= vleft_in;
               acc_ff   <= acc_in;
               rtype_ff <= rtype_in;
               bleft_ff <= bleft_in;
               err_ff   <= err_in;
            end
         end
      end
   end

endmodule

// ----- rtl/kvpsd_queue.sv -----
`timescale 1ns / 1ps
module kvpsd_queue #(
   parameter int DEPTH = kvpsd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  kvpsd_pkg::entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output kvpsd_pkg::entry_type pop_entry,
   output logic                 empty
);
   import kvpsd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- rtl/kvpsd_back.sv -----
`timescale 1ns / 1ps
module kvpsd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   input  kvpsd_pkg::entry_type pop_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_kind
);
   import kvpsd_pkg::*;

   logic     out_valid_ff;
   kind_type out_kind_ff;
   logic     second_valid_ff;
   kind_type second_kind_ff;
   logic     load;

   assign load      = !out_valid_ff || rsp_ready;
   assign pop       = load && !second_valid_ff && !empty;
   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         second_valid_ff <= 1'b0;
         out_kind_ff     <= KIND_PAIR;
         second_kind_ff  <= KIND_PAIR;
      end else if (load) begin
         if (second_valid_ff) begin
            out_valid_ff    <= 1'b1;
            out_kind_ff     <= second_kind_ff;
            second_valid_ff <= 1'b0;
         end else if (!empty) begin
            out_valid_ff    <= 1'b1;
            out_kind_ff     <= pop_entry.first_kind;
            second_valid_ff <= pop_entry.has_second;
            second_kind_ff  <= pop_entry.second_kind;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- rtl/key_value_pair_stream_decoder_top.sv -----
`timescale 1ns / 1ps
// Key/value parameter stream decoder.
// req_ channel: one item per buffer byte (req_data, req_data_valid) with
//   req_end_of_buffer marking the last item; an end-only item has
//   req_data_valid low.
// rsp_ channel: rsp_kind per result item (pair, header, value byte, error,
//   buffer done). An end item gives one or two results, others zero or one.
// csr_ port: csr_write_enable/csr_write_data set the largest allowed value
//   length; write only while the decoder is idle.
// Throughput: one input item per cycle while req_ready is high; the parser
//   does fixed work per byte (one 64-bit add for the type delta). The output
//   register gives one result per cycle while rsp_ready is high, so end items
//   with two results send them one after the other. Each result is written
//   into the queue when accepted, then moved into the output register.
// When rsp_ready is low the queue of QUEUE_DEPTH entries absorbs results;
//   req_ready drops once it is full.
// Reset: synchronous; parser state cleared, length limit back to 65535,
//   queue and output register emptied.
module key_value_pair_stream_decoder_top #(
   parameter int QUEUE_DEPTH = kvpsd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data,
   input  logic        req_data_valid,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import kvpsd_pkg::*;

   logic      accept;
   logic      push;
   entry_type push_entry;
   logic      full;
   logic      pop;
   entry_type pop_entry;
   logic      empty;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   kvpsd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data             (req_data),
      .data_valid       (req_data_valid),
      .end_of_buffer    (req_end_of_buffer),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .push_entry       (push_entry)
   );

   kvpsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (empty)
   );

   kvpsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_kind  (rsp_kind)
   );

endmodule
